// ===== design/gcm_ghash_top_macros.svh =====
// ----------------------------------------------------------------------------
// GHASH assertion macros
// Shared concurrent assertion forms for the GHASH checker.
// ----------------------------------------------------------------------------
`ifndef GCM_GHASH_TOP_MACROS_SVH
`define GCM_GHASH_TOP_MACROS_SVH

// Antecedent holds, consequent must hold in the next cycle.
`define GH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Antecedent holds, consequent must hold in the same cycle.
`define GH_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== design/gh_pkg.sv =====
// ----------------------------------------------------------------------------
// GHASH package
// Widths, codes, queue entry type and GF(2^128) helpers for the GHASH block.
// ----------------------------------------------------------------------------
package gh_pkg;

   localparam int BLOCK_W     = 128;
   localparam int HALF_W      = 64;
   localparam int LEN_W       = 64;
   localparam int CNT_W       = 5;
   localparam int FUNC_W      = 2;
   localparam int DIGIT_W     = 8;
   localparam int BLOCK_BYTES = BLOCK_W / 8;
   localparam int STEPS       = BLOCK_W / DIGIT_W;
   localparam int STEP_W      = $clog2(STEPS);
   localparam int REQ_DATA_W  = ((2 * HALF_W + CNT_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = 2 * HALF_W;
   localparam int CSR_IDX_W   = 1;
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(STEPS - 1);
   localparam logic [CNT_W-1:0]  FULL_BYTES  = CNT_W'(BLOCK_BYTES);
   localparam logic [7:0]        REDUCE_BYTE = 8'hE1;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HI = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LO = 1'b1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_AAD    = 2'd0,
      FUNC_CIPHER = 2'd1,
      FUNC_FINISH = 2'd2
   } func_type;

   typedef enum logic {
      ST_IDLE,
      ST_MUL
   } state_type;

   typedef struct packed {
      func_type             op;
      logic [BLOCK_W-1:0]   block;
      logic [CNT_W-1:0]     nbytes;
   } entry_type;

   // Multiply by x in the bit-reflected GCM field (field bit 0 is vector bit 127).
   function automatic logic [BLOCK_W-1:0] gf_mulx(input logic [BLOCK_W-1:0] v);
      logic [BLOCK_W-1:0] r;
      r = v >> 1;
      if (v[0]) begin
         r[BLOCK_W-1 -: 8] = r[BLOCK_W-1 -: 8] ^ REDUCE_BYTE;
      end
      return r;
   endfunction

   function automatic logic [BLOCK_W-1:0] gf_mulx_digit(input logic [BLOCK_W-1:0] v);
      logic [BLOCK_W-1:0] r;
      r = v;
      for (int i = 0; i < DIGIT_W; i++) begin
         r = gf_mulx(r);
      end
      return r;
   endfunction

endpackage

// ===== design/gh_front.sv =====
// ----------------------------------------------------------------------------
// GHASH front end
// Classifies incoming transactions, drops the ones with no effect, pads the
// block to its valid byte count and hands the result to the queue.
// ----------------------------------------------------------------------------
module gh_front
   import gh_pkg::*;
(
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [FUNC_W-1:0]     req_tuser,
   input  logic                  q_full,
   output logic                  q_push,
   output entry_type             q_entry
);

   logic [BLOCK_W-1:0] raw_block;
   logic [CNT_W-1:0]   raw_count;
   logic [CNT_W-1:0]   nbytes;
   logic               is_absorb;
   logic               is_finish;
   logic [BLOCK_W-1:0] padded;

   assign raw_block = {req_tdata[HALF_W-1:0], req_tdata[2*HALF_W-1:HALF_W]};
   assign raw_count = req_tdata[2*HALF_W +: CNT_W];
   assign nbytes    = (raw_count > FULL_BYTES) ? FULL_BYTES : raw_count;

   assign is_absorb = ((req_tuser == FUNC_AAD) || (req_tuser == FUNC_CIPHER)) &&
                      (raw_count != '0);
   assign is_finish = (req_tuser == FUNC_FINISH);

   // Byte 0 sits in the top byte of the block vector.
   always_comb begin
      for (int b = 0; b < BLOCK_BYTES; b++) begin
         padded[BLOCK_W-1-8*b -: 8] = (CNT_W'(b) < nbytes) ? raw_block[BLOCK_W-1-8*b -: 8]
                                                            : 8'h00;
      end
   end

   assign req_tready     = !q_full;
   assign q_push         = req_tvalid && req_tready && (is_absorb || is_finish);
   assign q_entry.op     = func_type'(req_tuser);
   assign q_entry.block  = padded;
   assign q_entry.nbytes = nbytes;

endmodule

// ===== design/gh_fifo.sv =====
// ----------------------------------------------------------------------------
// GHASH queue
// Short first-in first-out queue between the front end and the multiply
// engine.
// ----------------------------------------------------------------------------
module gh_fifo
   import gh_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      out_valid,
   output entry_type out_data
);

   entry_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/gh_back.sv =====
// ----------------------------------------------------------------------------
// GHASH multiply engine
// Holds the key, running tag, bit counts; multiplies by H one operand byte per
// cycle unless a finish is stalled. Drives the registered tag output.
// ----------------------------------------------------------------------------
module gh_back
   import gh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  entry_type             q_data,
   output logic                  q_pop,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [HALF_W-1:0]     csr_wdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   func_type           op_ff, op_in;
   logic [BLOCK_W-1:0] ysr_ff, ysr_in;
   logic [BLOCK_W-1:0] acc_ff, acc_in;
   logic [LEN_W-1:0]   aad_len_ff, aad_len_in;
   logic [LEN_W-1:0]   cip_len_ff, cip_len_in;
   logic [HALF_W-1:0]  key_hi_ff, key_hi_in;
   logic [HALF_W-1:0]  key_lo_ff, key_lo_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0] rsp_data_ff, rsp_data_in;

   logic [BLOCK_W-1:0] hx [DIGIT_W];
   logic [BLOCK_W-1:0] partial;
   logic [BLOCK_W-1:0] acc_step;
   logic [LEN_W-1:0]   add_bits;
   logic               last_step;
   logic               out_busy;
   logic               advance;

   // H times x^j for the eight bit positions of one operand byte.
   always_comb begin
      hx[0] = {key_hi_ff, key_lo_ff};
      for (int j = 1; j < DIGIT_W; j++) begin
         hx[j] = gf_mulx(hx[j-1]);
      end
   end

   // The lowest operand bit carries the highest power of x within the byte.
   always_comb begin
      partial = '0;
      for (int m = 0; m < DIGIT_W; m++) begin
         if (ysr_ff[m]) begin
            partial = partial ^ hx[DIGIT_W-1-m];
         end
      end
   end

   assign acc_step  = gf_mulx_digit(acc_ff) ^ partial;
   assign last_step = (step_ff == STEP_LAST);
   assign out_busy  = rsp_valid_ff && !rsp_tready;
   assign add_bits  = {{(LEN_W-CNT_W-3){1'b0}}, q_data.nbytes, 3'b000};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (last_step && !((op_ff == FUNC_FINISH) && out_busy)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop   = 1'b0;
      advance = 1'b0;
      unique case (state_ff)
         ST_IDLE: q_pop = q_valid;
         ST_MUL:  advance = !(last_step && (op_ff == FUNC_FINISH) && out_busy);
         default: begin
            q_pop   = 1'b0;
            advance = 1'b0;
         end
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      op_in        = op_ff;
      ysr_in       = ysr_ff;
      acc_in       = acc_ff;
      aad_len_in   = aad_len_ff;
      cip_len_in   = cip_len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      key_hi_in    = key_hi_ff;
      key_lo_in    = key_lo_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_HI: key_hi_in = csr_wdata;
            CSR_KEY_LO: key_lo_in = csr_wdata;
            default:    key_hi_in = key_hi_ff;
         endcase
      end

      if (q_pop) begin
         step_in = '0;
         op_in   = q_data.op;
         acc_in  = '0;
         case (q_data.op)
            FUNC_FINISH: begin
               ysr_in     = acc_ff ^ {aad_len_ff, cip_len_ff};
               aad_len_in = '0;
               cip_len_in = '0;
            end
            FUNC_AAD: begin
               ysr_in     = acc_ff ^ q_data.block;
               aad_len_in = aad_len_ff + add_bits;
            end
            default: begin
               ysr_in     = acc_ff ^ q_data.block;
               cip_len_in = cip_len_ff + add_bits;
            end
         endcase
      end else if (advance) begin
         step_in = step_ff + 1'b1;
         ysr_in  = ysr_ff >> DIGIT_W;
         acc_in  = acc_step;
         if (last_step && (op_ff == FUNC_FINISH)) begin
            acc_in       = '0;
            rsp_data_in  = acc_step;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         op_ff        <= FUNC_AAD;
         acc_ff       <= '0;
         aad_len_ff   <= '0;
         cip_len_ff   <= '0;
         key_hi_ff    <= '0;
         key_lo_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         op_ff        <= op_in;
         acc_ff       <= acc_in;
         aad_len_ff   <= aad_len_in;
         cip_len_ff   <= cip_len_in;
         key_hi_ff    <= key_hi_in;
         key_lo_ff    <= key_lo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ysr_ff      <= ysr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff[HALF_W-1:0], rsp_data_ff[BLOCK_W-1:HALF_W]};

endmodule

// ===== design/gcm_ghash_top.sv =====
// ----------------------------------------------------------------------------
// GCM GHASH top level
// Front end, queue and multiply engine of the GHASH authenticator.
// ----------------------------------------------------------------------------
// Each AAD, ciphertext or finish transaction occupies the shared GF(2^128)
// multiply unit: it loads the operand, then folds in the operand bytes one
// at a time. Transactions with an unused function code or a zero byte count
// are dropped in the front end. A two-entry queue lets the input side run
// ahead of the multiply unit, and the tag stays in an output register until
// taken while new transactions are still accepted. Key writes are taken on
// any cycle with no wait.
module gcm_ghash_top
   import gh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // block_hi, block_lo, valid_bytes, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic [FUNC_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tag_hi, tag_lo
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [HALF_W-1:0]     csr_wdata
);

   logic      q_full;
   logic      q_push;
   entry_type q_entry;
   logic      q_pop;
   logic      q_valid;
   entry_type q_data;

   gh_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   gh_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_entry),
      .full      (q_full),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_data  (q_data)
   );

   gh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== design/gh_checker.sv =====
// ----------------------------------------------------------------------------
// GHASH port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "gcm_ghash_top_macros.svh"

module gh_checker
   import gh_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [FUNC_W-1:0]     req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   `GH_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "tag dropped while stalled")
   `GH_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "tag changed while stalled")
   `GH_ASSERT_SAME(a_reset_quiet, $past(reset), !rsp_tvalid, "tag shown right after reset")
   // A finish needs the full multiply, so its tag cannot appear on the next cycle.
   `GH_ASSERT_SAME(a_tag_latency, $rose(rsp_tvalid), !$past(req_tvalid && req_tready && (req_tuser == FUNC_FINISH)), "tag appeared too soon after finish")

endmodule

bind gcm_ghash_top gh_checker u_checker (.*);

// ===== tb/gcm_ghash_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GHASH scoreboard
// Follows key writes and accepted blocks, computes every expected tag with a
// bit-serial GF(2^128) multiply and compares it with the tags the block emits.
// ----------------------------------------------------------------------------
module gcm_ghash_checker
   import gh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [FUNC_W-1:0]     req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [HALF_W-1:0]     csr_wdata,
   output int unsigned           mismatch_count,
   output int unsigned           tags_pending
);

   localparam logic [BLOCK_W-1:0] GF_REDUCE    = {8'hE1, {(BLOCK_W - 8){1'b0}}};
   localparam int                 REPORT_LIMIT = 10;

   // Vectors hold byte 0 in the top bits, so field bit 0 is vector bit 127.
   logic [BLOCK_W-1:0] hash_key;
   logic [BLOCK_W-1:0] tag_acc;
   logic [LEN_W-1:0]   aad_count;
   logic [LEN_W-1:0]   ct_bits;
   logic [BLOCK_W-1:0] tag_queue[$];
   int unsigned        errors;

   function automatic logic [BLOCK_W-1:0] gf_mult(input logic [BLOCK_W-1:0] x,
                                                  input logic [BLOCK_W-1:0] h);
      logic [BLOCK_W-1:0] z;
      logic [BLOCK_W-1:0] v;
      z = '0;
      v = h;
      for (int i = 0; i < BLOCK_W; i++) begin
         if (x[BLOCK_W - 1 - i]) begin
            z = z ^ v;
         end
         v = v[0] ? ((v >> 1) ^ GF_REDUCE) : (v >> 1);
      end
      return z;
   endfunction

   // Counts above a full block use the whole block.
   function automatic int unsigned used_bytes(input logic [CNT_W-1:0] nbytes);
      return (nbytes > BLOCK_BYTES) ? BLOCK_BYTES : nbytes;
   endfunction

   task automatic flag_mismatch(input string what, input logic [HALF_W-1:0] want,
                                input logic [HALF_W-1:0] got);
      errors++;
      if (errors <= REPORT_LIMIT) begin
         $display("[%0t] checker: %s expected %h, got %h", $time, what, want, got);
      end
   endtask

   initial begin
      errors = 0;
   end

   always @(posedge clock) begin : monitor
      logic [BLOCK_W-1:0] want;
      logic [BLOCK_W-1:0] blk;
      logic [CNT_W-1:0]   nbytes;
      int unsigned        n;
      if (reset) begin
         hash_key  = '0;
         tag_acc   = '0;
         aad_count = '0;
         ct_bits   = '0;
         tag_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_KEY_HI: hash_key[BLOCK_W-1 -: HALF_W] = csr_wdata;
               CSR_KEY_LO: hash_key[HALF_W-1:0] = csr_wdata;
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            if (tag_queue.size() == 0) begin
               flag_mismatch("tag with no finish pending, tag_hi", '0,
                             rsp_tdata[HALF_W-1:0]);
            end else begin
               want = tag_queue.pop_front();
               if (rsp_tdata[HALF_W-1:0] !== want[BLOCK_W-1 -: HALF_W]) begin
                  flag_mismatch("tag_hi", want[BLOCK_W-1 -: HALF_W], rsp_tdata[HALF_W-1:0]);
               end
               if (rsp_tdata[2*HALF_W-1:HALF_W] !== want[HALF_W-1:0]) begin
                  flag_mismatch("tag_lo", want[HALF_W-1:0], rsp_tdata[2*HALF_W-1:HALF_W]);
               end
            end
         end

         if (req_tvalid && req_tready) begin
            blk    = {req_tdata[HALF_W-1:0], req_tdata[2*HALF_W-1:HALF_W]};
            nbytes = req_tdata[2*HALF_W +: CNT_W];
            case (req_tuser)
               FUNC_FINISH: begin
                  // The length block carries the AAD bit count in its upper half.
                  tag_queue.push_back(gf_mult(tag_acc ^ {aad_count, ct_bits}, hash_key));
                  tag_acc   = '0;
                  aad_count = '0;
                  ct_bits   = '0;
               end
               FUNC_AAD, FUNC_CIPHER: begin
                  if (nbytes != 0) begin
                     n = used_bytes(nbytes);
                     tag_acc = gf_mult(tag_acc ^ (blk & ~({BLOCK_W{1'b1}} >> (8 * n))),
                                       hash_key);
                     if (req_tuser == FUNC_AAD) begin
                        aad_count = aad_count + LEN_W'(8 * n);
                     end else begin
                        ct_bits = ct_bits + LEN_W'(8 * n);
                     end
                  end
               end
               default: ;
            endcase
         end
      end
      mismatch_count <= errors;
      tags_pending   <= tag_queue.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GHASH testbench
// Loads several hash keys, sends directed and random AAD, ciphertext and
// finish transactions with random gaps and stalls, and lets the scoreboard
// check every tag.
// ----------------------------------------------------------------------------
module tb;
   import gh_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED     = 2'd3;
   localparam logic [HALF_W-1:0] ALL_ONES        = {HALF_W{1'b1}};
   localparam logic [HALF_W-1:0] FIELD_ONE       = {1'b1, {(HALF_W - 1){1'b0}}};
   localparam int                ITEM_TARGET     = 1450;
   localparam int                PHASES          = 6;
   localparam int                SETTLE_CYCLES   = 64;
   localparam int                RSP_HOLD_CYCLES = 300;
   localparam int                CYCLE_LIMIT     = 500000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [FUNC_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [HALF_W-1:0]     csr_wdata;
   int unsigned           mismatch_count;
   int unsigned           tags_pending;

   bit          idle_on    = 1'b1;
   bit          hold_rsp   = 1'b0;
   int unsigned items_sent = 0;

   gcm_ghash_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   gcm_ghash_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .tags_pending   (tags_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: FAIL");
      $finish;
   end

   // Tag receiver: random stalls, plus one long hold-off on request.
   initial begin : receiver
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   function automatic logic [HALF_W-1:0] rand_half();
      return {$urandom, $urandom};
   endfunction

   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [HALF_W-1:0] hi,
                            input logic [HALF_W-1:0] lo, input logic [CNT_W-1:0] nbytes);
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= REQ_DATA_W'({nbytes, lo, hi});
      do @(posedge clock); while (!req_tready);
      if (func == FUNC_FINISH || ((func == FUNC_AAD || func == FUNC_CIPHER) && nbytes != 0)) begin
         items_sent++;
      end
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_block(input logic [FUNC_W-1:0] func, input logic [CNT_W-1:0] nbytes);
      send_item(func, rand_half(), rand_half(), nbytes);
   endtask

   // Stop offering, wait for every tag, then give absorb work time to drain.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tags_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_key(input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo);
      csr_we    <= 1'b1;
      csr_index <= CSR_KEY_HI;
      csr_wdata <= hi;
      @(posedge clock);
      csr_index <= CSR_KEY_LO;
      csr_wdata <= lo;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [CNT_W-1:0] tail_size(input bit is_last);
      if (is_last && $urandom_range(0, 1) == 0) begin
         return CNT_W'($urandom_range(1, BLOCK_BYTES - 1));
      end
      return FULL_BYTES;
   endfunction

   // Occasional ignored, oversized or out-of-order transactions.
   task automatic maybe_noise();
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 3))
            0: send_block(FUNC_UNUSED, CNT_W'($urandom));
            1: send_block(($urandom_range(0, 1) == 0) ? FUNC_AAD : FUNC_CIPHER, '0);
            2: send_block(($urandom_range(0, 1) == 0) ? FUNC_AAD : FUNC_CIPHER,
                          CNT_W'($urandom_range(BLOCK_BYTES + 1, 31)));
            default: send_block(($urandom_range(0, 1) == 0) ? FUNC_AAD : FUNC_CIPHER,
                                CNT_W'($urandom_range(1, BLOCK_BYTES)));
         endcase
      end
   endtask

   task automatic send_message();
      int unsigned n_aad;
      int unsigned n_ct;
      n_aad = $urandom_range(0, 4);
      n_ct  = $urandom_range(0, 6);
      for (int i = 0; i < n_aad; i++) begin
         maybe_noise();
         send_block(FUNC_AAD, tail_size(i == n_aad - 1));
      end
      for (int i = 0; i < n_ct; i++) begin
         maybe_noise();
         send_block(FUNC_CIPHER, tail_size(i == n_ct - 1));
      end
      maybe_noise();
      send_block(FUNC_FINISH, CNT_W'($urandom));
   endtask

   initial begin : stimulus
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= FUNC_AAD;
      csr_we     <= 1'b0;
      csr_index  <= CSR_KEY_HI;
      csr_wdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The key is zero out of reset, so this tag must be zero.
      send_item(FUNC_AAD, ALL_ONES, ALL_ONES, FULL_BYTES);
      send_item(FUNC_FINISH, '0, '0, '0);
      quiesce();
      load_key(rand_half(), rand_half());

      // Empty message, with junk in the fields a finish ignores.
      send_item(FUNC_FINISH, ALL_ONES, ALL_ONES, '1);

      send_item(FUNC_AAD, ALL_ONES, ALL_ONES, FULL_BYTES);
      send_block(FUNC_AAD, CNT_W'(1));
      send_item(FUNC_CIPHER, '0, '0, FULL_BYTES);
      send_block(FUNC_CIPHER, CNT_W'(8));
      send_block(FUNC_CIPHER, CNT_W'(9));
      send_block(FUNC_CIPHER, CNT_W'(15));
      send_item(FUNC_FINISH, '0, '0, '0);

      send_block(FUNC_AAD, '0);
      send_block(FUNC_UNUSED, FULL_BYTES);
      send_block(FUNC_AAD, CNT_W'(17));
      send_item(FUNC_CIPHER, ALL_ONES, ALL_ONES, '1);
      send_block(FUNC_CIPHER, CNT_W'(3));
      send_block(FUNC_CIPHER, FULL_BYTES);
      send_block(FUNC_AAD, FULL_BYTES);
      send_item(FUNC_FINISH, '0, '0, '0);

      for (int p = 0; p < PHASES; p++) begin
         quiesce();
         case (p)
            1: load_key(ALL_ONES, ALL_ONES);
            2: load_key('0, '0);
            3: load_key(FIELD_ONE, '0);
            default: load_key(rand_half(), rand_half());
         endcase
         idle_on = (p != 3 && p != PHASES - 1);
         if (p == 1) begin
            // Tags back up behind the stalled receiver until input stalls too.
            hold_rsp = 1'b1;
            repeat (8) send_block(FUNC_FINISH, CNT_W'($urandom));
         end
         while (items_sent < ITEM_TARGET * (p + 1) / PHASES) begin
            send_message();
         end
      end

      quiesce();
      if (mismatch_count == 0 && tags_pending == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
